>>> design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property a implies b at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Property a implies b at the next edge.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> design/rmr_pkg.sv
// Shared constants for the rotation matrix renormalizer.
package rmr_pkg;
  // Width of the accumulators for norms, dot products and update sums.
  localparam int ACC_W = 64;
  // Number of matrix elements and of corrections.
  localparam int NUM_ELEM = 9;
  localparam int NUM_CORR = 6;
  // Correction slots: diagonal terms first, then the column pairs.
  localparam int E00 = 0;
  localparam int E11 = 1;
  localparam int E22 = 2;
  localparam int E01 = 3;
  localparam int E02 = 4;
  localparam int E12 = 5;
endpackage

>>> design/rmr_gram.sv
// Two-stage Gram unit: column square norms and column dot products.
module rmr_gram #(
  parameter int EW = 32,
  parameter int F  = 30
) (
  input  logic                           clk,
  input  logic                           ce,
  input  logic [9*EW-1:0]                m,
  output logic [3*rmr_pkg::ACC_W-1:0]    p,
  output logic [3*rmr_pkg::ACC_W-1:0]    d
);
  localparam int AW = rmr_pkg::ACC_W;
  localparam int PW = 2 * EW;

  logic signed [PW-1:0] ex [9];
  logic signed [PW-1:0] sqp [9];
  logic signed [PW-1:0] dtp [9];
  logic signed [AW-1:0] sq [9];
  logic signed [AW-1:0] dt [9];
  logic signed [AW-1:0] psum [3];
  logic signed [AW-1:0] dsum [3];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ex[i] = PW'($signed(m[i*EW +: EW]));
      sqp[i] = ex[i] * ex[i];
    end
    // Dot product terms per row: pairs (0,1), (0,2), (1,2).
    for (int r = 0; r < 3; r++) begin
      dtp[r*3]     = ex[r*3] * ex[r*3+1];
      dtp[r*3 + 1] = ex[r*3] * ex[r*3+2];
      dtp[r*3 + 2] = ex[r*3+1] * ex[r*3+2];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 9; i++) begin
        sq[i] <= AW'(sqp[i] >>> F);
        dt[i] <= AW'(dtp[i] >>> F);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        psum[c] <= sq[c] + sq[3+c] + sq[6+c];
        dsum[c] <= dt[c] + dt[3+c] + dt[6+c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p[c*AW +: AW] = psum[c];
      d[c*AW +: AW] = dsum[c];
    end
  end
endmodule

>>> design/rmr_div.sv
// Pipelined restoring divider with saturation to the element range.
module rmr_div #(
  parameter int EW = 32,
  parameter int F  = 30
) (
  input  logic                          clk,
  input  logic                          ce,
  input  logic [rmr_pkg::ACC_W-1:0]     num,
  input  logic [rmr_pkg::ACC_W-1:0]     den,
  output logic [EW-1:0]                 quo
);
  localparam int AW = rmr_pkg::ACC_W;
  localparam int RW = AW + 1;
  localparam logic [EW-1:0] QMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] QMIN = {1'b1, {(EW-1){1'b0}}};

  logic [RW-1:0] rem  [0:EW];
  logic [EW-1:0] low  [0:EW];
  logic [EW-1:0] qb   [0:EW];
  logic [AW-1:0] dv   [0:EW];
  logic          neg  [0:EW];
  logic          big  [0:EW];

  logic [AW-1:0] mag;
  logic [AW-1:0] shifted;

  assign mag     = num[AW-1] ? (~num + AW'(1)) : num;
  assign shifted = mag << F;

  // Setup stage. A quotient of EW or more bits only matters as saturated.
  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0] <= RW'(shifted >> EW);
      low[0] <= shifted[EW-1:0];
      qb[0]  <= '0;
      dv[0]  <= den;
      neg[0] <= num[AW-1];
      big[0] <= {{EW{1'b0}}, shifted} >= {den, {EW{1'b0}}};
    end
  end

  for (genvar i = 0; i < EW; i++) begin : g_step
    logic [RW-1:0] trial;
    logic          fits;
    assign trial = {rem[i][RW-2:0], low[i][EW-1]};
    assign fits  = trial >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (ce) begin
        rem[i+1] <= fits ? (trial - {1'b0, dv[i]}) : trial;
        low[i+1] <= low[i] << 1;
        qb[i+1]  <= {qb[i][EW-2:0], fits};
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
        big[i+1] <= big[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (!neg[EW]) begin
        quo <= (big[EW] || qb[EW] > QMAX) ? QMAX : qb[EW];
      end else begin
        quo <= (big[EW] || qb[EW] > QMIN) ? QMIN : (~qb[EW] + EW'(1));
      end
    end
  end
endmodule

>>> design/rmr_update.sv
// Two-stage in-place update of one matrix column.
module rmr_update #(
  parameter int EW  = 32,
  parameter int F   = 30,
  parameter int COL = 0
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic [9*EW-1:0]      m_in,
  input  logic [6*EW-1:0]      e_in,
  output logic [9*EW-1:0]      m_out,
  output logic [6*EW-1:0]      e_out
);
  localparam int AW = rmr_pkg::ACC_W;
  localparam int PW = 2 * EW;
  localparam logic signed [AW-1:0] EMAX = {{(AW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [AW-1:0] EMIN = ~EMAX;

  function automatic int coef_idx(input int k, input int j);
    int res;
    if (k == j) res = j;
    else if (k + j == 1) res = rmr_pkg::E01;
    else if (k + j == 2) res = rmr_pkg::E02;
    else res = rmr_pkg::E12;
    return res;
  endfunction

  logic signed [PW-1:0] prod [3][3];
  logic signed [AW-1:0] term [3][3];
  logic [9*EW-1:0]      m_a;
  logic [6*EW-1:0]      e_a;
  logic signed [AW-1:0] sum [3];
  logic [9*EW-1:0]      m_next;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        prod[r][j] = PW'($signed(e_in[coef_idx(COL, j)*EW +: EW]))
                   * PW'($signed(m_in[(r*3+j)*EW +: EW]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          term[r][j] <= AW'(prod[r][j] >>> F);
        end
      end
      m_a <= m_in;
      e_a <= e_in;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = AW'($signed(m_a[(r*3+COL)*EW +: EW]))
             + term[r][0] + term[r][1] + term[r][2];
    end
  end

  always_comb begin
    m_next = m_a;
    for (int r = 0; r < 3; r++) begin
      if (sum[r] > EMAX) begin
        m_next[(r*3+COL)*EW +: EW] = EMAX[EW-1:0];
      end else if (sum[r] < EMIN) begin
        m_next[(r*3+COL)*EW +: EW] = EMIN[EW-1:0];
      end else begin
        m_next[(r*3+COL)*EW +: EW] = sum[r][EW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_out <= m_next;
      e_out <= e_a;
    end
  end
endmodule

>>> design/rotation_matrix_renormalize_top.sv
// Top level of the first-order rotation matrix renormalizer.
//
// One 3x3 rotation matrix enters per input word on the s_axis channel and
// one corrected matrix leaves per output word on the m_axis channel, in the
// same order. The block forms the column norms and dot products, divides
// for six corrections and updates column 0, then 1, then 2 in place, with
// saturation to the element range.
// The divider retires one quotient bit per stage. A new matrix can enter
// in every cycle unless the receiver stalls with a word waiting, so
// throughput is one word per cycle while the output is not stalled.
// When a column norm is zero the input matrix comes out unchanged with
// tuser set.
// Reset clears only the valid bits; the data registers are not reset.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and s_axis_tready drops; no word is lost or repeated.
`include "assert_macros.svh"
module rotation_matrix_renormalize_top #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRAC_BITS     = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero fill
  input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // n00, n01, n02, n10, n11, n12, n20, n21, n22, zero fill
  output logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // divide_fault
  output logic                  m_axis_tuser
);
  localparam int EW  = ELEMENT_WIDTH;
  localparam int AW  = rmr_pkg::ACC_W;
  localparam int MW  = 9 * EW;
  localparam int LAT = EW + 12;
  localparam int DIV_OUT = EW + 6;
  localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  logic            ce;
  logic [LAT:1]    vld;
  logic [MW-1:0]   mline [1:LAT];
  logic [LAT:4]    fline;
  logic [3*AW-1:0] p;
  logic [3*AW-1:0] d;
  logic [AW-1:0]   pn [3];
  logic [AW-1:0]   dn [3];
  logic [AW-1:0]   num [6];
  logic [AW-1:0]   den [6];
  logic [6*EW-1:0] e0;
  logic [6*EW-1:0] e1;
  logic [6*EW-1:0] e2;
  logic [6*EW-1:0] e3;
  logic [MW-1:0]   m1;
  logic [MW-1:0]   m2;
  logic [MW-1:0]   m3;

  assign ce            = !vld[LAT] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-1:1], s_axis_tvalid};
    end
  end

  // Original matrix travels alongside for the zero-norm pass-through.
  always_ff @(posedge clk) begin
    if (ce) begin
      mline[1] <= s_axis_tdata[MW-1:0];
      for (int i = 2; i <= LAT; i++) begin
        mline[i] <= mline[i-1];
      end
    end
  end

  rmr_gram #(.EW(EW), .F(FRAC_BITS)) u_gram (
    .clk (clk),
    .ce  (ce),
    .m   (mline[1]),
    .p   (p),
    .d   (d)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pn[c] = p[c*AW +: AW];
      dn[c] = d[c*AW +: AW];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fline[4] <= (pn[0] == '0) || (pn[1] == '0) || (pn[2] == '0);
      for (int i = 5; i <= LAT; i++) begin
        fline[i] <= fline[i-1];
      end
      num[rmr_pkg::E00] <= ONE - pn[0];
      num[rmr_pkg::E11] <= ONE - pn[1];
      num[rmr_pkg::E22] <= ONE - pn[2];
      num[rmr_pkg::E01] <= '0 - dn[0];
      num[rmr_pkg::E02] <= '0 - dn[1];
      num[rmr_pkg::E12] <= '0 - dn[2];
      den[rmr_pkg::E00] <= pn[0];
      den[rmr_pkg::E11] <= pn[1];
      den[rmr_pkg::E22] <= pn[2];
      den[rmr_pkg::E01] <= pn[0] + pn[1];
      den[rmr_pkg::E02] <= pn[0] + pn[2];
      den[rmr_pkg::E12] <= pn[1] + pn[2];
    end
  end

  for (genvar k = 0; k < rmr_pkg::NUM_CORR; k++) begin : g_div
    rmr_div #(.EW(EW), .F(FRAC_BITS)) u_div (
      .clk (clk),
      .ce  (ce),
      .num (num[k]),
      .den (den[k]),
      .quo (e0[k*EW +: EW])
    );
  end

  rmr_update #(.EW(EW), .F(FRAC_BITS), .COL(0)) u_upd0 (
    .clk (clk), .ce (ce), .m_in (mline[DIV_OUT]), .e_in (e0),
    .m_out (m1), .e_out (e1)
  );
  rmr_update #(.EW(EW), .F(FRAC_BITS), .COL(1)) u_upd1 (
    .clk (clk), .ce (ce), .m_in (m1), .e_in (e1),
    .m_out (m2), .e_out (e2)
  );
  rmr_update #(.EW(EW), .F(FRAC_BITS), .COL(2)) u_upd2 (
    .clk (clk), .ce (ce), .m_in (m2), .e_in (e2),
    .m_out (m3), .e_out (e3)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[MW-1:0] = fline[LAT] ? mline[LAT] : m3;
    m_axis_tuser = fline[LAT];
  end

  // The corrections leaving the last column stage are not needed further.
  logic unused_e;
  assign unused_e = ^e3;

  `ASSERT_NEXT(a_stall_holds, clk, rst, vld[LAT] && !m_axis_tready, $stable(vld))
  `ASSERT_NEXT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready, vld[1])
  `ASSERT_NEXT(a_last_moves, clk, rst, ce && vld[LAT-1], vld[LAT])
endmodule
